// File: hdl/pbfs_pkg.sv
// shared types and constants for the packed bit field store
package pbfs_pkg;

   localparam int WORD_BITS = 64;
   localparam int POS_W     = 15;
   localparam int WIDTH_W   = 7;
   localparam int OFF_W     = 6;
   localparam int WIDX_W    = POS_W - OFF_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

endpackage

// File: hdl/pbfs_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pbfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/packed_bit_field_store.sv
// packed bit field store: bit-addressed field read and write over a word memory
// banks are read on transfer; the result is registered once the output is free
// no new request until the last completes (read, then modify and write back)
// words are split into even and odd banks so a straddling field reads both at once
// reset: a clearing pass zeroes the store, walking both banks together,
// during which req_stall stays high
module packed_bit_field_store #(
   parameter int STORE_WORDS    = 512,
   parameter int MAX_FIELD_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [pbfs_pkg::POS_W-1:0]         req_bit_position,
   input  logic [pbfs_pkg::WIDTH_W-1:0]       req_field_width,
   input  logic                               req_is_signed,
   input  logic [pbfs_pkg::WORD_BITS-1:0]     req_write_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pbfs_pkg::WORD_BITS-1:0]     rsp_read_value,
   output logic                               rsp_range_error
);

   import pbfs_pkg::*;

   localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int ODD_DEPTH  = STORE_WORDS / 2;
   localparam int EAW        = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
   localparam int OAW        = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
   localparam int TOTAL_BITS = STORE_WORDS * WORD_BITS;

   state_type state_ff, state_in;

   logic [EAW-1:0] clr_ff, clr_in;

   // item registers
   logic                 kind_ff;
   logic [OFF_W-1:0]     off_ff;
   logic                 wlsb_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic                 sgn_ff;
   logic [WORD_BITS-1:0] val_ff;
   logic                 err_ff;
   logic                 zero_ff;
   logic                 straddle_ff;
   logic [EAW-1:0]       even_addr_ff;
   logic [OAW-1:0]       odd_addr_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_value_ff;
   logic                 rsp_err_ff;

   logic accept;
   logic done;

   logic [WIDX_W:0]  widx_p1;
   logic [EAW-1:0]   req_even_addr;
   logic [OAW-1:0]   req_odd_addr;
   logic [31:0]      req_end;
   logic             req_err;
   logic             req_straddle;

   logic                 even_we, odd_we;
   logic [EAW-1:0]       even_waddr;
   logic [OAW-1:0]       odd_waddr;
   logic [WORD_BITS-1:0] even_wdata, odd_wdata;
   logic [WORD_BITS-1:0] even_rdata, odd_rdata;

   logic [2*WORD_BITS-1:0] win;
   logic [2*WORD_BITS-1:0] win_shl;
   logic [2*WORD_BITS-1:0] new_win;
   logic [2*WORD_BITS-1:0] mask_win;
   logic [2*WORD_BITS-1:0] data_win;
   logic [WORD_BITS-1:0]   top_word;
   logic [WORD_BITS-1:0]   ones_hi;
   logic [WORD_BITS-1:0]   field_rd;
   logic [WORD_BITS-1:0]   field_ext;
   logic [WORD_BITS-1:0]   mask_top;
   logic [WORD_BITS-1:0]   val_top;
   logic [WIDTH_W-1:0]     rsh;
   logic                   do_write;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_BUSY) && (!rsp_valid_ff || !rsp_stall);

   // word w sits in bank w[0]; odd bank address is w/2, even bank (w+1)/2
   assign widx_p1       = {1'b0, req_bit_position[POS_W-1:OFF_W]} + (WIDX_W+1)'(1);
   assign req_even_addr = EAW'(widx_p1[WIDX_W:1]);
   assign req_odd_addr  = OAW'(req_bit_position[POS_W-1:OFF_W+1]);
   assign req_end       = 32'(req_bit_position) + 32'(req_field_width);
   assign req_err       = (req_field_width > WIDTH_W'(MAX_FIELD_BITS))
                          || (req_end > 32'(TOTAL_BITS));
   assign req_straddle  = ((WIDTH_W'(req_bit_position[OFF_W-1:0]) + req_field_width)
                           > WIDTH_W'(WORD_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_kind;
         off_ff       <= req_bit_position[OFF_W-1:0];
         wlsb_ff      <= req_bit_position[OFF_W];
         width_ff     <= req_field_width;
         sgn_ff       <= req_is_signed;
         val_ff       <= req_write_value;
         err_ff       <= req_err;
         zero_ff      <= (req_field_width == '0);
         straddle_ff  <= req_straddle;
         even_addr_ff <= req_even_addr;
         odd_addr_ff  <= req_odd_addr;
      end
      if (done) begin
         rsp_value_ff <= (kind_ff == KIND_READ && !err_ff && !zero_ff) ? field_ext : '0;
         rsp_err_ff   <= err_ff && !zero_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + EAW'(1);
            if (clr_ff == EAW'(EVEN_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // 128-bit window: first word in the upper half
   always_comb begin
      win      = wlsb_ff ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};
      win_shl  = win << off_ff;
      top_word = win_shl[2*WORD_BITS-1:WORD_BITS];
      rsh      = WIDTH_W'(WORD_BITS) - width_ff;
      ones_hi  = {WORD_BITS{1'b1}} << width_ff;
      field_rd = top_word >> rsh;
      // sign comes from the first field bit, which is the top of the window
      field_ext = (sgn_ff && top_word[WORD_BITS-1]) ? (field_rd | ones_hi) : field_rd;
      mask_top = (~ones_hi) << rsh;
      val_top  = (val_ff & ~ones_hi) << rsh;
      mask_win = {mask_top, {WORD_BITS{1'b0}}} >> off_ff;
      data_win = {val_top, {WORD_BITS{1'b0}}} >> off_ff;
      new_win  = (win & ~mask_win) | data_win;
   end

   assign do_write = done && (kind_ff == KIND_WRITE) && !err_ff && !zero_ff;

   always_comb begin
      even_we    = 1'b0;
      odd_we     = 1'b0;
      even_waddr = even_addr_ff;
      odd_waddr  = odd_addr_ff;
      even_wdata = '0;
      odd_wdata  = '0;
      if (state_ff == ST_CLEAR) begin
         even_we   = 1'b1;
         odd_we    = ({1'b0, clr_ff} < (EAW+1)'(ODD_DEPTH));
         even_waddr = clr_ff;
         odd_waddr  = OAW'(clr_ff);
      end else if (do_write) begin
         if (wlsb_ff) begin
            odd_we     = 1'b1;
            odd_wdata  = new_win[2*WORD_BITS-1:WORD_BITS];
            even_we    = straddle_ff;
            even_wdata = new_win[WORD_BITS-1:0];
         end else begin
            even_we    = 1'b1;
            even_wdata = new_win[2*WORD_BITS-1:WORD_BITS];
            odd_we     = straddle_ff;
            odd_wdata  = new_win[WORD_BITS-1:0];
         end
      end
   end

   pbfs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (EVEN_DEPTH),
      .AW    (EAW)
   ) u_even_ram (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_waddr),
      .wr_data (even_wdata),
      .rd_en   (accept),
      .rd_addr (req_even_addr),
      .rd_data (even_rdata)
   );

   pbfs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ODD_DEPTH),
      .AW    (OAW)
   ) u_odd_ram (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_waddr),
      .wr_data (odd_wdata),
      .rd_en   (accept),
      .rd_addr (req_odd_addr),
      .rd_data (odd_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule
